FILE: hdl/vp8bd_pkg.sv
// Shared types, constants and a helper function for the boolean decoder.
// No dependencies; imported by every other module of the block but the RAM.
package vp8bd_pkg;

  localparam int BYTE_STORE_DEPTH = 16;
  localparam int BS_AW = $clog2(BYTE_STORE_DEPTH);
  localparam int BS_FW = $clog2(BYTE_STORE_DEPTH + 1);

  localparam int CMDQ_DEPTH = 2;
  localparam int CQ_AW = $clog2(CMDQ_DEPTH);
  localparam int CQ_CW = $clog2(CMDQ_DEPTH + 1);

  localparam logic [7:0] RANGE_INIT = 8'd255;
  localparam logic [7:0] PROB_HALF = 8'd128;
  localparam logic [3:0] LIT_MAX_BITS = 4'd8;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_PUSH  = 2'd1,
    KIND_BIT   = 2'd2,
    KIND_LIT   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    LF_PLAIN  = 2'd0,
    LF_SIGNED = 2'd1,
    LF_FLAG   = 2'd2
  } lit_form_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] prob;
    logic [3:0] bits;
    lit_form_t  form;
  } cmd_t;

  function automatic logic [2:0] lzc8(input logic [7:0] v);
    logic [2:0] lz;
    logic       found;
    lz = 3'd0;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) begin
          found = 1'b1;
        end else begin
          lz = lz + 3'd1;
        end
      end
    end
    return lz;
  endfunction

endpackage

FILE: hdl/vp8bd_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
// No dependencies.
module vp8bd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/vp8bd_front.sv
// Input stage: accepts words, classifies them and registers a command.
// Depends on vp8bd_pkg.
module vp8bd_front
  import vp8bd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_first_byte,
  input  logic [7:0] in_second_byte,
  input  logic       in_partition_short,
  input  logic [7:0] in_probability,
  input  logic [3:0] in_literal_bits,
  input  logic [1:0] in_literal_form,
  output logic       q_push,
  output cmd_t       q_cmd,
  input  logic       q_full
);

  logic fr_valid_r, fr_valid_nxt;
  cmd_t fr_cmd_r, fr_cmd_nxt;
  logic accept;

  assign full   = fr_valid_r && q_full;
  assign accept = push && !full;

  always_comb begin
    fr_cmd_nxt = fr_cmd_r;
    if (accept) begin
      fr_cmd_nxt.kind  = kind_t'(in_kind);
      fr_cmd_nxt.byte0 = in_first_byte;
      fr_cmd_nxt.byte1 = in_second_byte;
      fr_cmd_nxt.prob  = in_probability;
      fr_cmd_nxt.bits  = (in_literal_bits > LIT_MAX_BITS) ? LIT_MAX_BITS : in_literal_bits;
      case (lit_form_t'(in_literal_form))
        LF_SIGNED: fr_cmd_nxt.form = LF_SIGNED;
        LF_FLAG:   fr_cmd_nxt.form = LF_FLAG;
        default:   fr_cmd_nxt.form = LF_PLAIN;
      endcase
      if (kind_t'(in_kind) == KIND_START && in_partition_short) begin
        fr_cmd_nxt.byte0 = 8'd0;
        fr_cmd_nxt.byte1 = 8'd0;
      end
      if (kind_t'(in_kind) == KIND_LIT) begin
        fr_cmd_nxt.prob = PROB_HALF;
      end
    end
  end

  assign fr_valid_nxt = accept || (fr_valid_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_cmd_r <= fr_cmd_nxt;
  end

  assign q_push = fr_valid_r && !q_full;
  assign q_cmd  = fr_cmd_r;

endmodule

FILE: hdl/vp8bd_cmdq.sv
// Short command queue between the input stage and the decode engine.
// Depends on vp8bd_pkg.
module vp8bd_cmdq
  import vp8bd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_push,
  input  cmd_t q_in,
  output logic q_full,
  input  logic q_pop,
  output logic q_valid,
  output cmd_t q_head
);

  cmd_t             ent_r [CMDQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CQ_CW-1:0] cnt_r;
  logic             do_push, do_pop;

  assign q_full  = (cnt_r == CQ_CW'(CMDQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && q_valid;
  assign q_head  = ent_r[rd_ptr_r];

  function automatic logic [CQ_AW-1:0] inc_ptr(input logic [CQ_AW-1:0] p);
    return (p == CQ_AW'(CMDQ_DEPTH - 1)) ? '0 : p + CQ_AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= inc_ptr(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= inc_ptr(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CQ_CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CQ_CW'(1);
      end
    end
    if (do_push) begin
      ent_r[wr_ptr_r] <= q_in;
    end
  end

endmodule

FILE: hdl/vp8bd_engine.sv
// Decode engine: coder state, byte store control, bit decode and literal sequencing.
// Depends on vp8bd_pkg; drives the byte store RAM and the result register.
module vp8bd_engine
  import vp8bd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  cmd_t             q_head,
  output logic             q_pop,
  output logic             ram_wr_en,
  output logic [BS_AW-1:0] ram_wr_addr,
  output logic [7:0]       ram_wr_data,
  output logic [BS_AW-1:0] ram_rd_addr,
  input  logic [7:0]       ram_rd_data,
  input  logic             pop,
  output logic             empty,
  output logic signed [8:0] out_symbol_value
);

  typedef enum logic [3:0] {
    ST_FETCH = 4'b0001,
    ST_MUL   = 4'b0010,
    ST_NORM  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    PH_SINGLE = 4'b0001,
    PH_FLAG   = 4'b0010,
    PH_MAG    = 4'b0100,
    PH_SIGN   = 4'b1000
  } phase_t;

  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       range_r, range_nxt;
  logic [15:0]      value_r, value_nxt;
  logic [2:0]       sc_r, sc_nxt;
  logic [BS_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [BS_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [BS_FW-1:0] fill_r, fill_nxt;
  logic [7:0]       prob_r, prob_nxt;
  logic [7:0]       split_r, split_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [7:0]       acc_r, acc_nxt;
  logic             sgn_r, sgn_nxt;
  logic [8:0]       res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [8:0]       out_value_r, out_value_nxt;

  logic [15:0] prod;
  logic [15:0] point;
  logic        dbit;
  logic [7:0]  range_t;
  logic [15:0] value_t;
  logic [2:0]  lz;
  logic [3:0]  sum;
  logic        take;
  logic [7:0]  byte_in;
  logic [7:0]  acc_sh;
  logic        load_out;

  function automatic logic [BS_AW-1:0] inc_ptr(input logic [BS_AW-1:0] p);
    return (p == BS_AW'(BYTE_STORE_DEPTH - 1)) ? '0 : p + BS_AW'(1);
  endfunction

  assign prod    = {8'd0, range_r - 8'd1} * {8'd0, prob_r};
  assign point   = {split_r, 8'd0};
  assign dbit    = (value_r >= point);
  assign range_t = dbit ? (range_r - split_r) : split_r;
  assign value_t = dbit ? (value_r - point) : value_r;
  assign lz      = lzc8(range_t);
  assign sum     = {1'b0, sc_r} + {1'b0, lz};
  assign take    = sum[3] && (fill_r != '0);
  assign byte_in = take ? ram_rd_data : 8'd0;
  assign acc_sh  = {acc_r[6:0], dbit};

  assign ram_rd_addr = rd_ptr_r;
  assign ram_wr_addr = wr_ptr_r;
  assign ram_wr_data = q_head.byte0;

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || pop);

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    range_nxt  = range_r;
    value_nxt  = value_r;
    sc_nxt     = sc_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    fill_nxt   = fill_r;
    prob_nxt   = prob_r;
    split_nxt  = split_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    sgn_nxt    = sgn_r;
    res_nxt    = res_r;
    q_pop      = 1'b0;
    ram_wr_en  = 1'b0;
    case (state_r)
      ST_FETCH: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          prob_nxt = q_head.prob;
          cnt_nxt  = q_head.bits;
          acc_nxt  = 8'd0;
          sgn_nxt  = (q_head.form != LF_PLAIN);
          case (q_head.kind)
            KIND_START: begin
              value_nxt  = {q_head.byte0, q_head.byte1};
              range_nxt  = RANGE_INIT;
              sc_nxt     = 3'd0;
              rd_ptr_nxt = '0;
              wr_ptr_nxt = '0;
              fill_nxt   = '0;
            end
            KIND_PUSH: begin
              if (fill_r < BS_FW'(BYTE_STORE_DEPTH)) begin
                ram_wr_en  = 1'b1;
                wr_ptr_nxt = inc_ptr(wr_ptr_r);
                fill_nxt   = fill_r + BS_FW'(1);
              end
            end
            KIND_BIT: begin
              phase_nxt = PH_SINGLE;
              state_nxt = ST_MUL;
            end
            default: begin
              case (q_head.form)
                LF_FLAG: begin
                  phase_nxt = PH_FLAG;
                  state_nxt = ST_MUL;
                end
                LF_SIGNED: begin
                  phase_nxt = (q_head.bits == 4'd0) ? PH_SIGN : PH_MAG;
                  state_nxt = ST_MUL;
                end
                default: begin
                  if (q_head.bits == 4'd0) begin
                    res_nxt   = 9'd0;
                    state_nxt = ST_DONE;
                  end else begin
                    phase_nxt = PH_MAG;
                    state_nxt = ST_MUL;
                  end
                end
              endcase
            end
          endcase
        end
      end
      ST_MUL: begin
        split_nxt = prod[15:8] + 8'd1;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        range_nxt = range_t << lz;
        value_nxt = (value_t << lz) | ({8'd0, byte_in} << sum[2:0]);
        sc_nxt    = sum[2:0];
        if (take) begin
          rd_ptr_nxt = inc_ptr(rd_ptr_r);
          fill_nxt   = fill_r - BS_FW'(1);
        end
        state_nxt = ST_MUL;
        case (phase_r)
          PH_SINGLE: begin
            res_nxt   = {8'd0, dbit};
            state_nxt = ST_DONE;
          end
          PH_FLAG: begin
            if (!dbit) begin
              res_nxt   = 9'd0;
              state_nxt = ST_DONE;
            end else begin
              phase_nxt = (cnt_r == 4'd0) ? PH_SIGN : PH_MAG;
            end
          end
          PH_MAG: begin
            acc_nxt = acc_sh;
            cnt_nxt = cnt_r - 4'd1;
            if (cnt_r == 4'd1) begin
              if (sgn_r) begin
                phase_nxt = PH_SIGN;
              end else begin
                res_nxt   = {1'b0, acc_sh};
                state_nxt = ST_DONE;
              end
            end
          end
          default: begin
            res_nxt   = dbit ? (9'd0 - {1'b0, acc_r}) : {1'b0, acc_r};
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_FETCH;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FETCH;
      phase_r     <= PH_SINGLE;
      range_r     <= RANGE_INIT;
      value_r     <= 16'd0;
      sc_r        <= 3'd0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      range_r     <= range_nxt;
      value_r     <= value_nxt;
      sc_r        <= sc_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prob_r      <= prob_nxt;
    split_r     <= split_nxt;
    cnt_r       <= cnt_nxt;
    acc_r       <= acc_nxt;
    sgn_r       <= sgn_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

  assign empty            = !out_valid_r;
  assign out_symbol_value = $signed(out_value_r);

`ifndef ASSERT_OFF
  a_range_norm: assert property (@(posedge clk) disable iff (!rst_n) range_r[7])
    else $error("coder range left normalized interval");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= BS_FW'(BYTE_STORE_DEPTH))
    else $error("byte store fill above depth");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty byte store with unequal pointers");
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (out_valid_r && state_r == ST_FETCH))
    else $error("result word not held after load");
`endif

endmodule

FILE: hdl/vp8_boolean_decoder.sv
// Channel  | Ports                                 | Word accepted when
// ---------+---------------------------------------+--------------------
// input    | push, full, in_*                      | push && !full
// result   | pop, empty, out_symbol_value          | pop && !empty
//
// Start and push words are handled in the fetch state alone; a symbol decode
// passes through fetch, split multiply, normalize with byte refill and
// deliver; a literal repeats split multiply and normalize for each decoded
// bit, one bit per iteration, and the split multiply result is registered.
// Reset is synchronous; the byte store RAM is not cleared and needs no pass.
// full rises when the input register and the two-entry command queue are
// both occupied; the engine holds in deliver while a result waits.
// Depends on vp8bd_pkg, vp8bd_front, vp8bd_cmdq, vp8bd_engine, vp8bd_ram.
module vp8_boolean_decoder
  import vp8bd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_kind,
  input  logic [7:0]        in_first_byte,
  input  logic [7:0]        in_second_byte,
  input  logic              in_partition_short,
  input  logic [7:0]        in_probability,
  input  logic [3:0]        in_literal_bits,
  input  logic [1:0]        in_literal_form,
  input  logic              pop,
  output logic              empty,
  output logic signed [8:0] out_symbol_value
);

  cmd_t             fr_cmd;
  cmd_t             q_head;
  logic             q_push, q_full, q_valid, q_pop;
  logic             ram_wr_en;
  logic [BS_AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [7:0]       ram_wr_data, ram_rd_data;

  vp8bd_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_kind            (in_kind),
    .in_first_byte      (in_first_byte),
    .in_second_byte     (in_second_byte),
    .in_partition_short (in_partition_short),
    .in_probability     (in_probability),
    .in_literal_bits    (in_literal_bits),
    .in_literal_form    (in_literal_form),
    .q_push             (q_push),
    .q_cmd              (fr_cmd),
    .q_full             (q_full)
  );

  vp8bd_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_in    (fr_cmd),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  vp8bd_ram #(
    .WIDTH (8),
    .DEPTH (BYTE_STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  vp8bd_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .ram_wr_en        (ram_wr_en),
    .ram_wr_addr      (ram_wr_addr),
    .ram_wr_data      (ram_wr_data),
    .ram_rd_addr      (ram_rd_addr),
    .ram_rd_data      (ram_rd_data),
    .pop              (pop),
    .empty            (empty),
    .out_symbol_value (out_symbol_value)
  );

endmodule
